// File: src/mbt_pkg.sv
// Shared constants, beat types and helpers for the maze backtracker step core.
package mbt_pkg;

    localparam int ROWS    = 32;
    localparam int COLS    = 32;
    localparam int NCELLS  = ROWS * COLS;
    localparam int RW      = $clog2(ROWS);
    localparam int CW      = $clog2(COLS);
    localparam int CELL_W  = $clog2(NCELLS);
    localparam int DEPTH_W = $clog2(NCELLS + 1);
    localparam int STK_W   = RW + CW;
    localparam int ENT_W   = 5;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;

    localparam logic [2:0] EV_CARVED      = 3'd0;
    localparam logic [2:0] EV_BACKTRACKED = 3'd1;
    localparam logic [2:0] EV_FINISHED    = 3'd2;
    localparam logic [2:0] EV_STARTED     = 3'd3;
    localparam logic [2:0] EV_WALLS       = 3'd4;

    localparam logic [1:0] DIR_LEFT   = 2'd0;
    localparam logic [1:0] DIR_BOTTOM = 2'd1;
    localparam logic [1:0] DIR_RIGHT  = 2'd2;
    localparam logic [1:0] DIR_TOP    = 2'd3;

    localparam logic [3:0] WALLS_ALL = 4'hf;

    typedef struct packed {
        logic [1:0] action;
        logic [4:0] row;
        logic [4:0] col;
        logic [7:0] random_value;
    } req_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [4:0]  cell_row;
        logic [4:0]  cell_col;
        logic [1:0]  direction;
        logic [3:0]  walls;
        logic [10:0] visited_total;
    } rsp_t;

    typedef struct packed {
        logic       found;
        logic [1:0] dir;
    } pick_t;

    function automatic logic [CELL_W-1:0] cell_idx(input logic [RW-1:0] r,
                                                   input logic [CW-1:0] c);
        cell_idx = CELL_W'(r * COLS + c);
    endfunction

endpackage

// File: src/mbt_ram.sv
// Generic simple dual-port RAM with registered read.
module mbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/mbt_pick.sv
// Candidate selection: count open neighbours and pick one by random index.
module mbt_pick (
    input  logic [3:0]      avail,
    input  logic [7:0]      rnd,
    output mbt_pkg::pick_t  pick
);
    import mbt_pkg::*;

    logic [2:0]  n;
    logic [15:0] prod;
    logic [6:0]  q;
    logic [7:0]  rem3;
    logic [1:0]  sel;
    logic [1:0]  cnt;
    logic        hit;

    assign n    = 3'($countones(avail));
    assign prod = {8'd0, rnd} * 16'd171;
    assign q    = prod[15:9];
    assign rem3 = rnd - {q, 1'b0} - {1'b0, q};

    always_comb
    begin
        case (n)
            3'd2:    sel = {1'b0, rnd[0]};
            3'd3:    sel = rem3[1:0];
            3'd4:    sel = rnd[1:0];
            default: sel = 2'd0;
        endcase
    end

    always_comb
    begin
        cnt        = 2'd0;
        hit        = 1'b0;
        pick.dir   = DIR_LEFT;
        pick.found = |avail;
        for (int i = 0; i < 4; i++)
        begin
            if (avail[i] && !hit && cnt == sel)
            begin
                pick.dir = 2'(i);
                hit      = 1'b1;
            end
            if (avail[i])
            begin
                cnt = cnt + 2'd1;
            end
        end
    end

endmodule

// File: src/maze_backtracker_step_core.sv
// Top level of the maze backtracker step core: sequencer around the cell and stack stores.
// Carves a maze over a ROWS by COLS grid by randomised depth-first search, one command per
// beat, one result beat per command. Cell walls and visited marks share one single-port-read
// store, the search stack a second; every command is worked through these one access at a
// time. After reset and on every start command the cell store is swept back to all walls
// standing, one cell a cycle, and no command is taken during the sweep. A carve step makes
// five reads (current cell and four neighbours) through the cell store's read port and two
// wall writes; a backtrack, which finds no open neighbour after the same reads, also reads
// the popped cell's walls unless it empties the stack. After the result beat is loaded the
// core returns to idle before the next command is taken. A finished result waits in an
// output register while the next command is taken.
module maze_backtracker_step_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  mbt_pkg::req_t   req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output mbt_pkg::rsp_t   rsp
);
    import mbt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_CUR,
        S_NBR,
        S_WAIT,
        S_DEC,
        S_WNXT,
        S_POP,
        S_POPCELL,
        S_POPWALL,
        S_RDCELL,
        S_RDWALL,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic                start_pend_reg;
    logic [CELL_W-1:0]   clr_cnt_reg;
    logic [RW-1:0]       row_reg;
    logic [CW-1:0]       col_reg;
    logic [CELL_W-1:0]   idx_reg;
    logic [7:0]          rnd_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [10:0]         count_reg;
    logic [2:0]          k_reg;
    logic                cap_v_reg;
    logic [2:0]          cap_k_reg;
    logic [3:0]          avail_reg;
    logic [3:0]          walls_cur_reg;
    logic [1:0]          dir_reg;
    rsp_t                res_reg;
    rsp_t                rsp_reg;
    logic                rsp_valid_reg;

    logic                cell_we;
    logic [CELL_W-1:0]   cell_waddr;
    logic [ENT_W-1:0]    cell_wdata;
    logic [CELL_W-1:0]   cell_raddr;
    logic [ENT_W-1:0]    cell_rdata;
    logic                stk_we;
    logic [CELL_W-1:0]   stk_waddr;
    logic [STK_W-1:0]    stk_wdata;
    logic [STK_W-1:0]    stk_rdata;
    logic [DEPTH_W-1:0]  depth_m1;
    logic [3:0]          ingrid;
    pick_t               pick;
    logic [RW-1:0]       nxt_row;
    logic [CW-1:0]       nxt_col;
    logic [CELL_W-1:0]   nxt_idx;
    logic [CELL_W-1:0]   nbr_addr;
    logic [RW-1:0]       sat_row;
    logic [CW-1:0]       sat_col;
    logic [RW-1:0]       stk_row;
    logic [CW-1:0]       stk_col;
    logic                req_fire;
    logic                push_ok;

    assign req_stall = (state_reg != S_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign depth_m1 = depth_reg - DEPTH_W'(1);
    assign push_ok  = (depth_reg < DEPTH_W'(NCELLS));
    assign stk_row  = stk_rdata[STK_W-1:CW];
    assign stk_col  = stk_rdata[CW-1:0];

    assign sat_row = (req.row >= ROWS) ? RW'(ROWS - 1) : RW'(req.row);
    assign sat_col = (req.col >= COLS) ? CW'(COLS - 1) : CW'(req.col);

    assign ingrid[0] = (col_reg != '0);
    assign ingrid[1] = (row_reg != RW'(ROWS - 1));
    assign ingrid[2] = (col_reg != CW'(COLS - 1));
    assign ingrid[3] = (row_reg != '0);

    mbt_pick u_pick (
        .avail (avail_reg & ingrid),
        .rnd   (rnd_reg),
        .pick  (pick)
    );

    always_comb
    begin
        nxt_row = row_reg;
        nxt_col = col_reg;
        nxt_idx = idx_reg;
        case (pick.dir)
            DIR_LEFT:
            begin
                nxt_col = col_reg - CW'(1);
                nxt_idx = idx_reg - CELL_W'(1);
            end
            DIR_BOTTOM:
            begin
                nxt_row = row_reg + RW'(1);
                nxt_idx = idx_reg + CELL_W'(COLS);
            end
            DIR_RIGHT:
            begin
                nxt_col = col_reg + CW'(1);
                nxt_idx = idx_reg + CELL_W'(1);
            end
            default:
            begin
                nxt_row = row_reg - RW'(1);
                nxt_idx = idx_reg - CELL_W'(COLS);
            end
        endcase
    end

    always_comb
    begin
        case (k_reg)
            3'd1:    nbr_addr = idx_reg - CELL_W'(1);
            3'd2:    nbr_addr = idx_reg + CELL_W'(COLS);
            3'd3:    nbr_addr = idx_reg + CELL_W'(1);
            3'd4:    nbr_addr = idx_reg - CELL_W'(COLS);
            default: nbr_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_NBR:     cell_raddr = nbr_addr;
            S_POPCELL: cell_raddr = cell_idx(stk_row, stk_col);
            default:   cell_raddr = idx_reg;
        endcase
    end

    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = idx_reg;
        cell_wdata = {1'b1, WALLS_ALL};
        stk_we     = 1'b0;
        stk_waddr  = depth_reg[CELL_W-1:0];
        stk_wdata  = {nxt_row, nxt_col};
        case (state_reg)
            S_CLEAR:
            begin
                cell_we    = 1'b1;
                cell_waddr = clr_cnt_reg;
                cell_wdata = {1'b0, WALLS_ALL};
            end
            S_START:
            begin
                cell_we   = 1'b1;
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = {row_reg, col_reg};
            end
            S_DEC:
            begin
                cell_we    = pick.found;
                cell_wdata = {1'b1, walls_cur_reg & ~(4'd1 << pick.dir)};
                stk_we     = pick.found && push_ok;
            end
            S_WNXT:
            begin
                cell_we    = 1'b1;
                cell_wdata = {1'b1, WALLS_ALL & ~(4'd1 << (dir_reg ^ 2'd2))};
            end
            default:
            begin
                cell_we = 1'b0;
            end
        endcase
    end

    mbt_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NCELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    mbt_ram #(
        .WIDTH (STK_W),
        .DEPTH (NCELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (depth_m1[CELL_W-1:0]),
        .rdata (stk_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            start_pend_reg <= 1'b0;
            clr_cnt_reg    <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            idx_reg        <= '0;
            rnd_reg        <= '0;
            depth_reg      <= '0;
            count_reg      <= '0;
            k_reg          <= '0;
            cap_v_reg      <= 1'b0;
            cap_k_reg      <= '0;
            avail_reg      <= '0;
            walls_cur_reg  <= '0;
            dir_reg        <= '0;
            res_reg        <= '0;
            rsp_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            cap_v_reg <= (state_reg == S_NBR);
            if (cap_v_reg)
            begin
                if (cap_k_reg == 3'd0)
                begin
                    walls_cur_reg <= cell_rdata[3:0];
                end
                else
                begin
                    avail_reg[2'(cap_k_reg - 3'd1)] <= !cell_rdata[4];
                end
            end

            if (rsp_valid_reg && !rsp_stall && state_reg != S_EMIT)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_cnt_reg == CELL_W'(NCELLS - 1))
                    begin
                        clr_cnt_reg    <= '0;
                        start_pend_reg <= 1'b0;
                        state_reg      <= start_pend_reg ? S_START : S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + CELL_W'(1);
                    end
                end
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        row_reg <= sat_row;
                        col_reg <= sat_col;
                        idx_reg <= cell_idx(sat_row, sat_col);
                        rnd_reg <= req.random_value;
                        case (req.action)
                            ACT_START:
                            begin
                                start_pend_reg <= 1'b1;
                                state_reg      <= S_CLEAR;
                            end
                            ACT_STEP:
                            begin
                                if (depth_reg == '0)
                                begin
                                    res_reg <= '{EV_FINISHED, 5'd0, 5'd0, DIR_LEFT, 4'd0,
                                                 count_reg};
                                    state_reg <= S_EMIT;
                                end
                                else
                                begin
                                    state_reg <= S_CUR;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_RDCELL;
                            end
                        endcase
                    end
                end
                S_START:
                begin
                    depth_reg <= DEPTH_W'(1);
                    count_reg <= '0;
                    res_reg   <= '{EV_STARTED, 5'(row_reg), 5'(col_reg), DIR_LEFT,
                                   WALLS_ALL, 11'd0};
                    state_reg <= S_EMIT;
                end
                S_CUR:
                begin
                    row_reg   <= stk_row;
                    col_reg   <= stk_col;
                    idx_reg   <= cell_idx(stk_row, stk_col);
                    k_reg     <= '0;
                    state_reg <= S_NBR;
                end
                S_NBR:
                begin
                    cap_k_reg <= k_reg;
                    k_reg     <= k_reg + 3'd1;
                    if (k_reg == 3'd4)
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_DEC;
                end
                S_DEC:
                begin
                    if (pick.found)
                    begin
                        row_reg   <= nxt_row;
                        col_reg   <= nxt_col;
                        idx_reg   <= nxt_idx;
                        dir_reg   <= pick.dir;
                        state_reg <= S_WNXT;
                    end
                    else
                    begin
                        depth_reg <= depth_m1;
                        if (depth_m1 == '0)
                        begin
                            res_reg <= '{EV_BACKTRACKED, 5'd0, 5'd0, DIR_LEFT, 4'd0,
                                         count_reg};
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            state_reg <= S_POP;
                        end
                    end
                end
                S_WNXT:
                begin
                    if (push_ok)
                    begin
                        depth_reg <= depth_reg + DEPTH_W'(1);
                    end
                    count_reg <= count_reg + 11'd1;
                    res_reg   <= '{EV_CARVED, 5'(row_reg), 5'(col_reg), dir_reg,
                                   cell_wdata[3:0], count_reg + 11'd1};
                    state_reg <= S_EMIT;
                end
                S_POP:
                begin
                    state_reg <= S_POPCELL;
                end
                S_POPCELL:
                begin
                    row_reg   <= stk_row;
                    col_reg   <= stk_col;
                    state_reg <= S_POPWALL;
                end
                S_POPWALL:
                begin
                    res_reg   <= '{EV_BACKTRACKED, 5'(row_reg), 5'(col_reg), DIR_LEFT,
                                   cell_rdata[3:0], count_reg};
                    state_reg <= S_EMIT;
                end
                S_RDCELL:
                begin
                    state_reg <= S_RDWALL;
                end
                S_RDWALL:
                begin
                    res_reg   <= '{EV_WALLS, 5'(row_reg), 5'(col_reg), DIR_LEFT,
                                   cell_rdata[3:0], count_reg};
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!rsp_valid_reg || !rsp_stall)
                    begin
                        rsp_reg       <= res_reg;
                        rsp_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(NCELLS))
        else $error("stack depth beyond grid size");

    a_beat_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result beat raised outside emit");

    a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> (cell_we && cell_wdata == {1'b0, WALLS_ALL}))
        else $error("sweep does not restore cell");

    a_carve_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WNXT) |=> (count_reg == $past(count_reg) + 11'd1))
        else $error("carve did not advance count");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> req_stall)
        else $error("command taken during sweep");
`endif

endmodule
